FILE: hw/rtl/kca_pkg.sv
// Shared types and constants for the k-means centroid accumulator.
// No dependencies; used by every module of the block.
package kca_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ACCUM = 2'd1;
    localparam logic [1:0] OP_NORM  = 2'd2;

    localparam int SUM_W  = 48;
    localparam int NORM_W = 37;
    localparam int IDX_W  = 6;
    localparam int MAX_DEPTH = 64;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

    // One queued request for the back end
    typedef struct packed {
        logic [1:0]         op;
        logic               ok;
        logic [IDX_W-1:0]   idx;
        logic signed [15:0] sample;
        logic [15:0]        weight;
        logic [31:0]        ws;
        logic               last;
    } t_cmd;

    // Back-end status used by the top-level checks
    typedef struct packed {
        logic div_start;
        logic div_busy;
        logic emit;
        logic pop;
    } t_back_stat;

endpackage

FILE: hw/rtl/kca_front.sv
// Front end: accepts requests, drops unused opcodes, range-checks the index
// and queues the rest in a two-entry queue. Depends on kca_pkg.
module kca_front #(
    parameter int VECTOR_DIM = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_opcode,
    input  logic [5:0]                i_element_index,
    input  logic signed [15:0]        i_sample_value,
    input  logic [15:0]               i_weight,
    input  logic [31:0]               i_weight_sum,
    input  logic                      i_last_element,
    output kca_pkg::t_cmd             o_cmd,
    output logic                      o_cmd_valid,
    input  logic                      i_pop
);
    localparam logic [10:0] DIM = 11'(VECTOR_DIM);

    kca_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          push;
    logic          pop;
    kca_pkg::t_cmd cmd;

    assign o_ready     = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign pop         = i_pop && o_cmd_valid;
    assign push        = i_valid && o_ready && (i_opcode != 2'd3);

    // Classify the request
    always_comb begin
        cmd.op     = i_opcode;
        cmd.ok     = ({5'd0, i_element_index} < DIM);
        cmd.idx    = i_element_index;
        cmd.sample = i_sample_value;
        cmd.weight = i_weight;
        cmd.ws     = i_weight_sum;
        cmd.last   = i_last_element;
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            if (push && !pop)      r_count <= r_count + 2'd1;
            else if (pop && !push) r_count <= r_count - 2'd1;
        end
    end
endmodule

FILE: hw/rtl/kca_div.sv
// Iterative radix-4 divider: 48-bit magnitude by 32-bit divisor, two quotient
// bits per cycle. Depends on kca_pkg.
module kca_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kca_pkg::SUM_W-1:0]   i_dividend,
    input  logic [31:0]                 i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [kca_pkg::SUM_W-1:0]   o_quo
);
    localparam logic [4:0] STEPS = 5'(kca_pkg::SUM_W / 2);

    logic [31:0]               r_rem;
    logic [kca_pkg::SUM_W-1:0] r_quo;
    logic [31:0]               r_d;
    logic [4:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [32:0]               t1;
    logic [32:0]               t2;
    logic [31:0]               rem1;
    logic [31:0]               rem2;
    logic                      b1;
    logic                      b2;

    // Two restoring steps
    always_comb begin
        t1   = {r_rem, r_quo[kca_pkg::SUM_W-1]};
        b1   = (t1 >= {1'b0, r_d});
        rem1 = b1 ? 32'(t1 - {1'b0, r_d}) : t1[31:0];
        t2   = {rem1, r_quo[kca_pkg::SUM_W-2]};
        b2   = (t2 >= {1'b0, r_d});
        rem2 = b2 ? 32'(t2 - {1'b0, r_d}) : t2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= rem2;
            r_quo <= {r_quo[kca_pkg::SUM_W-3:0], b1, b2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: hw/rtl/kca_back.sv
// Back end: sum and centroid memories, accumulate, normalize through the
// divider, norm and flag bookkeeping. Depends on kca_pkg and kca_div.
module kca_back #(
    parameter int VECTOR_DIM = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kca_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_pop,
    input  logic                        i_out_free,
    output logic                        o_emit,
    output logic [kca_pkg::NORM_W-1:0]  o_norm,
    output logic                        o_changed,
    output logic                        o_error,
    output kca_pkg::t_back_stat         o_stat
);
    localparam int DEPTH = (VECTOR_DIM < kca_pkg::MAX_DEPTH) ? VECTOR_DIM
                                                             : kca_pkg::MAX_DEPTH;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_SQ   = 3'd5;
    localparam logic [2:0] S_NORM = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic signed [kca_pkg::SUM_W-1:0] sum_mem [DEPTH];
    logic signed [15:0]               cent_mem [DEPTH];
    logic [DEPTH-1:0]                 r_cvld;

    logic [2:0]                       r_state;
    kca_pkg::t_cmd                    r_cmd;
    logic signed [kca_pkg::SUM_W-1:0] r_sum_rd;
    logic signed [15:0]               r_cent_rd;
    logic                             r_cvld_rd;
    logic signed [32:0]               r_prod;
    logic signed [15:0]               r_q;
    logic [30:0]                      r_sq;
    logic [kca_pkg::NORM_W-1:0]       r_norm;
    logic                             r_chg;
    logic                             r_err;
    logic                             r_neg;

    logic [AW-1:0]                    addr;
    logic [AW-1:0]                    head_addr;
    logic signed [15:0]               cent_old;
    logic signed [kca_pkg::SUM_W:0]   sum_ext;
    logic signed [kca_pkg::SUM_W-1:0] sum_sat;
    logic [kca_pkg::SUM_W-1:0]        mag;
    logic [16:0]                      q_sat;
    logic signed [15:0]               q_res;
    logic [kca_pkg::NORM_W:0]         norm_ext;
    logic                             div_start;
    logic                             div_busy;
    logic                             div_done;
    logic [kca_pkg::SUM_W-1:0]        div_quo;
    logic                             pop;
    logic                             wr_sum;
    logic                             wr_cent;

    assign addr      = r_cmd.idx[AW-1:0];
    assign head_addr = i_cmd.idx[AW-1:0];
    assign cent_old  = r_cvld_rd ? r_cent_rd : 16'sd0;
    assign pop       = (r_state == S_IDLE) && i_cmd_valid;

    // Saturating accumulate
    always_comb begin
        sum_ext = {r_sum_rd[kca_pkg::SUM_W-1], r_sum_rd} + (kca_pkg::SUM_W+1)'(r_prod);
        if (sum_ext[kca_pkg::SUM_W] != sum_ext[kca_pkg::SUM_W-1]) begin
            sum_sat = sum_ext[kca_pkg::SUM_W] ? kca_pkg::SUM_MIN : kca_pkg::SUM_MAX;
        end else begin
            sum_sat = sum_ext[kca_pkg::SUM_W-1:0];
        end
    end

    // Dividend magnitude and quotient clamp
    always_comb begin
        mag = r_sum_rd[kca_pkg::SUM_W-1] ? kca_pkg::SUM_W'(-r_sum_rd)
                                         : kca_pkg::SUM_W'(r_sum_rd);
        if (r_neg) begin
            q_sat = (div_quo > 48'd32768) ? 17'd32768 : div_quo[16:0];
            q_res = 16'(-q_sat);
        end else begin
            q_sat = (div_quo > 48'd32767) ? 17'd32767 : div_quo[16:0];
            q_res = q_sat[15:0];
        end
        norm_ext = {1'b0, r_norm} + (kca_pkg::NORM_W+1)'(r_sq);
    end

    assign div_start = (r_state == S_READ) && (r_cmd.op == kca_pkg::OP_NORM)
                       && r_cmd.ok && (r_cmd.ws != 32'd0);
    assign wr_sum  = ((r_state == S_READ) && (r_cmd.op == kca_pkg::OP_CLEAR) && r_cmd.ok)
                     || (r_state == S_ACC);
    assign wr_cent = (r_state == S_FIN);

    kca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag),
        .i_divisor  (r_cmd.ws),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Memories: read on pop, write from the sequencer
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_sum_rd  <= sum_mem[head_addr];
            r_cent_rd <= cent_mem[head_addr];
        end
        if (wr_sum) begin
            sum_mem[addr] <= (r_state == S_ACC) ? sum_sat : '0;
        end
        if (wr_cent) begin
            cent_mem[addr] <= q_res;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (pop) r_cmd <= i_cmd;
        if (r_state == S_READ) begin
            r_prod <= r_cmd.sample * $signed({1'b0, r_cmd.weight});
            r_neg  <= r_sum_rd[kca_pkg::SUM_W-1];
            r_q    <= cent_old;
        end
        if (r_state == S_FIN) r_q  <= q_res;
        if (r_state == S_SQ)  r_sq <= 31'(r_q * r_q);
    end

    // Sequencer and running values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cvld    <= '0;
            r_cvld_rd <= 1'b0;
            r_norm    <= '0;
            r_chg     <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            if (pop) r_cvld_rd <= r_cvld[head_addr];
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) r_state <= S_READ;
                end
                S_READ: begin
                    unique case (r_cmd.op)
                        kca_pkg::OP_ACCUM: r_state <= r_cmd.ok ? S_ACC : S_IDLE;
                        kca_pkg::OP_NORM: begin
                            if (!r_cmd.ok) begin
                                r_state <= r_cmd.last ? S_EMIT : S_IDLE;
                            end else if (r_cmd.ws == 32'd0) begin
                                r_err   <= 1'b1;
                                r_state <= S_SQ;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_ACC: r_state <= S_IDLE;
                S_DIV: begin
                    if (div_done) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (q_res != cent_old) r_chg <= 1'b1;
                    r_cvld[addr] <= 1'b1;
                    r_state      <= S_SQ;
                end
                S_SQ: r_state <= S_NORM;
                S_NORM: begin
                    r_norm  <= norm_ext[kca_pkg::NORM_W] ? kca_pkg::NORM_MAX
                                                         : norm_ext[kca_pkg::NORM_W-1:0];
                    r_state <= r_cmd.last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (i_out_free) begin
                        r_norm  <= '0;
                        r_chg   <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pop     = pop;
    assign o_emit    = (r_state == S_EMIT) && i_out_free;
    assign o_norm    = r_norm;
    assign o_changed = r_chg;
    assign o_error   = r_err;

    always_comb begin
        o_stat.div_start = div_start;
        o_stat.div_busy  = div_busy;
        o_stat.emit      = (r_state == S_EMIT) && i_out_free;
        o_stat.pop       = pop;
    end
endmodule

FILE: hw/rtl/kmeans_centroid_accumulator_unit.sv
// K-means centroid update engine. One request per element: clear, accumulate
// (sum += sample * weight, saturating at 48 bits) or normalize (sum / weight
// sum into a Q8.8 centroid, norm and change/error flags; the last one emits a
// result). Once the back end pops a request, clear zeroes the sum in the read
// state, and accumulate adds the product in a following accumulate state.
// Normalize waits on the radix-4 divider, which produces two quotient bits per
// cycle, then writes the centroid, squares it and adds it to the norm. The last
// element of a pass then waits to hand off the result. A normalize with a
// zero weight sum skips the divider. A two-entry queue keeps accepting while it
// has a free entry, and the result register holds a finished result until it is taken.
// Depends on kca_pkg, kca_front and kca_back.
module kmeans_centroid_accumulator_unit #(
    parameter int VECTOR_DIM = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [5:0]         i_element_index,
    input  logic signed [15:0] i_sample_value,
    input  logic [15:0]        i_weight,
    input  logic [31:0]        i_weight_sum,
    input  logic               i_last_element,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [36:0]        o_centroid_norm,
    output logic               o_centroid_changed,
    output logic               o_divide_error
);
    kca_pkg::t_cmd              cmd;
    logic                       cmd_valid;
    logic                       pop;
    logic                       out_free;
    logic                       emit;
    logic [kca_pkg::NORM_W-1:0] norm;
    logic                       changed;
    logic                       error;
    kca_pkg::t_back_stat        stat;
    logic                       r_out_valid;
    logic [kca_pkg::NORM_W-1:0] r_out_norm;
    logic                       r_out_chg;
    logic                       r_out_err;

    kca_front #(.VECTOR_DIM(VECTOR_DIM)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_element_index (i_element_index),
        .i_sample_value  (i_sample_value),
        .i_weight        (i_weight),
        .i_weight_sum    (i_weight_sum),
        .i_last_element  (i_last_element),
        .o_cmd           (cmd),
        .o_cmd_valid     (cmd_valid),
        .i_pop           (pop)
    );

    kca_back #(.VECTOR_DIM(VECTOR_DIM)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_pop       (pop),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_norm      (norm),
        .o_changed   (changed),
        .o_error     (error),
        .o_stat      (stat)
    );

    assign out_free = !r_out_valid || i_ready;

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_norm <= norm;
            r_out_chg  <= changed;
            r_out_err  <= error;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_centroid_norm    = r_out_norm;
    assign o_centroid_changed = r_out_chg;
    assign o_divide_error     = r_out_err;

`ifndef ASSERT_OFF
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.emit |-> (!r_out_valid || i_ready))
        else $error("result overwrote an untaken result");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pop |-> cmd_valid)
        else $error("pop from empty queue");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.emit |=> r_out_valid)
        else $error("emitted result not presented");
`endif
endmodule
